// ----- hw/rtl/modexp_pkg.sv -----
// Package for the modular exponentiation block.
// Holds the input and output word types and the multiplier status type.
// No dependencies.
package modexp_pkg;

	// One input word: base, exponent and modulus, all unsigned.
	typedef struct packed {
		logic [31:0] base;
		logic [31:0] exponent;
		logic [31:0] modulus;
	} in_word_t;

	// One output word: the power and the zero modulus flag.
	typedef struct packed {
		logic [31:0] power_result;
		logic        zero_modulus_error;
	} out_word_t;

	// Status of the shared modular multiplier.
	typedef struct packed {
		logic busy;
		logic done;
	} mm_status_t;

endpackage

// ----- hw/rtl/modular_exponentiation_top.sv -----
// Modular exponentiation, right-to-left square-and-multiply on one shared multiplier.
// A word takes (L + 1) to 2L multiplications on the shared unit, L being the exponent's
// bit length. Words are taken one at a time: in_ready is high only in the idle state.
// Zero exponent or zero modulus skips the multiplier: the word goes straight from idle
// to the finish state, where the result is registered for output.
// Reset clears control only. Depends on modexp_pkg and modexp_mulmod.
module modular_exponentiation_top #(
	parameter int WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  modexp_pkg::in_word_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output modexp_pkg::out_word_t out_data
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_REDUCE = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_MUL    = 3'd3;
	localparam logic [2:0] S_SQR    = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0]            state_q;
	logic [2:0]            state_d;
	logic [WIDTH-1:0]      e_q;
	logic [WIDTH-1:0]      acc_q;
	logic [WIDTH-1:0]      sq_q;
	logic [WIDTH-1:0]      mod_q;
	modexp_pkg::out_word_t res_q;
	modexp_pkg::out_word_t out_q;
	logic                  out_valid_q;

	logic [WIDTH-1:0] base_w;
	logic [WIDTH-1:0] exp_w;
	logic [WIDTH-1:0] mod_w;
	logic [WIDTH-1:0] one_r;
	logic [WIDTH-1:0] fin_acc;
	logic [31:0]      fin_res;
	logic             accept;
	logic             finish_go;

	logic                   mm_start;
	logic [WIDTH-1:0]       mm_x;
	logic [WIDTH-1:0]       mm_y;
	logic [WIDTH-1:0]       mm_n;
	logic [WIDTH-1:0]       mm_r;
	modexp_pkg::mm_status_t mm_st;

	// The input fields are masked or zero-extended to the datapath width, and the
	// accumulator is cut or zero-extended back to the 32-bit result field.
	generate
		if (WIDTH > 32) begin : g_wide
			assign base_w  = {{(WIDTH-32){1'b0}}, in_data.base};
			assign exp_w   = {{(WIDTH-32){1'b0}}, in_data.exponent};
			assign mod_w   = {{(WIDTH-32){1'b0}}, in_data.modulus};
			assign fin_res = fin_acc[31:0];
		end else if (WIDTH == 32) begin : g_equal
			assign base_w  = in_data.base;
			assign exp_w   = in_data.exponent;
			assign mod_w   = in_data.modulus;
			assign fin_res = fin_acc;
		end else begin : g_narrow
			assign base_w  = in_data.base[WIDTH-1:0];
			assign exp_w   = in_data.exponent[WIDTH-1:0];
			assign mod_w   = in_data.modulus[WIDTH-1:0];
			assign fin_res = {{(32-WIDTH){1'b0}}, fin_acc};
		end
	endgenerate

	// One reduced modulo n: zero when the modulus is one.
	assign one_r = {{(WIDTH-1){1'b0}}, (mod_w != {{(WIDTH-1){1'b0}}, 1'b1})};

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign finish_go = !out_valid_q || out_ready;

	// The accumulator that ends the run comes straight from the multiplier when
	// the last set exponent bit has just been multiplied in.
	assign fin_acc = (state_q == S_MUL) ? mm_r : acc_q;

	// Multiplier launches. The base is first reduced by multiplying it with one
	// modulo n, so every later operand is below the modulus as the unit needs.
	// The input word may change once taken, so later launches use the held modulus.
	always_comb begin
		mm_start = 1'b0;
		mm_x     = sq_q;
		mm_y     = sq_q;
		mm_n     = mod_q;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mod_w == '0 || exp_w == '0) begin
						state_d = S_FINISH;
					end else begin
						mm_start = 1'b1;
						mm_x     = one_r;
						mm_y     = base_w;
						mm_n     = mod_w;
						state_d  = S_REDUCE;
					end
				end
			end
			S_REDUCE: begin
				if (mm_st.done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (e_q == '0) begin
					state_d = S_FINISH;
				end else if (e_q[0]) begin
					mm_start = 1'b1;
					mm_x     = acc_q;
					state_d  = S_MUL;
				end else begin
					mm_start = 1'b1;
					state_d  = S_SQR;
				end
			end
			S_MUL: begin
				if (mm_st.done) begin
					if (e_q[WIDTH-1:1] != '0) begin
						mm_start = 1'b1;
						state_d  = S_SQR;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SQR: begin
				if (mm_st.done) begin
					state_d = S_DECIDE;
				end
			end
			S_FINISH: begin
				if (finish_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FINISH && finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers. The modulus is held here for every launch after the first.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				e_q   <= exp_w;
				mod_q <= mod_w;
				if (mod_w == '0) begin
					res_q.power_result       <= '0;
					res_q.zero_modulus_error <= 1'b1;
				end else begin
					res_q.power_result       <= 32'd1;
					res_q.zero_modulus_error <= 1'b0;
				end
				acc_q <= one_r;
			end
			S_REDUCE: begin
				if (mm_st.done) begin
					sq_q <= mm_r;
				end
			end
			S_DECIDE: begin
				if (e_q == '0) begin
					res_q.power_result       <= fin_res;
					res_q.zero_modulus_error <= 1'b0;
				end else if (!e_q[0]) begin
					e_q <= e_q >> 1;
				end
			end
			S_MUL: begin
				if (mm_st.done) begin
					acc_q                    <= mm_r;
					e_q                      <= e_q >> 1;
					res_q.power_result       <= fin_res;
					res_q.zero_modulus_error <= 1'b0;
				end
			end
			S_SQR: begin
				if (mm_st.done) begin
					sq_q <= mm_r;
				end
			end
			S_FINISH: begin
				if (finish_go) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	modexp_mulmod #(
		.WIDTH(WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.x      (mm_x),
		.y      (mm_y),
		.n      (mm_n),
		.r      (mm_r),
		.status (mm_st)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// An accepted word always takes the sequencer out of idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
	else $error("input taken again right after a word was accepted");

	// The multiplier is only launched when it is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |-> !mm_st.busy)
	else $error("multiplier launched while busy");

	// A finished multiplication is only seen in a state that waits for one.
	assert property (@(posedge clk) disable iff (!arst_n)
		mm_st.done |-> (state_q == S_REDUCE || state_q == S_MUL || state_q == S_SQR))
	else $error("multiplier finished outside a multiply state");

	// The zero modulus flag always comes with a zero result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.zero_modulus_error) |-> (out_q.power_result == 32'd0))
	else $error("zero modulus flag with a nonzero result");

endmodule

// ----- hw/rtl/modexp_mulmod.sv -----
// Bit-serial modular multiplier, one bit of the multiplier operand per cycle.
// Depends on modexp_pkg for the status type.
module modexp_mulmod #(
	parameter int WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [WIDTH-1:0]       x,
	input  logic [WIDTH-1:0]       y,
	input  logic [WIDTH-1:0]       n,
	output logic [WIDTH-1:0]       r,
	output modexp_pkg::mm_status_t status
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] r_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] n_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH+1:0] sum;
	logic [WIDTH+1:0] n1;
	logic [WIDTH+1:0] n2;
	logic [WIDTH+1:0] red;

	// The partial result stays below n and x is below n, so 2r + x is below 3n.
	// Comparing against n and 2n in parallel settles the reduction in one step.
	always_comb begin
		n1  = {2'b00, n_q};
		n2  = {1'b0, n_q, 1'b0};
		sum = {1'b0, r_q, 1'b0} + (y_q[WIDTH-1] ? {2'b00, x_q} : '0);
		priority if (sum >= n2) begin
			red = sum - n2;
		end else if (sum >= n1) begin
			red = sum - n1;
		end else begin
			red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			x_q <= x;
			y_q <= y;
			n_q <= n;
		end else if (busy_q) begin
			r_q <= red[WIDTH-1:0];
			y_q <= {y_q[WIDTH-2:0], 1'b0};
		end
	end

	assign r           = r_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule
